// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RQ_ASSERT(lbl, clk, rst_n, prop)
`define RQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/rqpi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring queue package
// Shared constants, codes, types and index arithmetic for the ring queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rqpi_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int IN_W   = ((DATA_W + 7) / 8) * 8;
    localparam int OUT_W  = ((DATA_W + 2 + STAT_W + 7) / 8) * 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_PRIO = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } stat_t;

    typedef struct packed {
        logic clr;
        logic en;
    } scan_ctl_t;

    typedef struct packed {
        logic found;
        idx_t pos;
    } scan_res_t;

    // Sum of two slot indices, both below SLOTS, wrapped into the ring.
    function automatic idx_t slot_add(input idx_t a, input idx_t b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (IDX_W+1)'(SLOTS)) begin
            sum = sum - (IDX_W+1)'(SLOTS);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic idx_t slot_inc(input idx_t a);
        return slot_add(a, idx_t'(1));
    endfunction

    // Number of stored entries between head and tail.
    function automatic idx_t slot_fill(input idx_t head, input idx_t tail);
        logic [IDX_W:0] diff;
        if (tail >= head) begin
            diff = {1'b0, tail} - {1'b0, head};
        end else begin
            diff = {1'b0, tail} + (IDX_W+1)'(SLOTS) - {1'b0, head};
        end
        return diff[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rqpi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/rqpi_scan.sv =====
// ----------------------------------------------------------------------------
// Priority scan unit
// Compares one stored entry per cycle, while ctl.en is set, against the new value and tracks the
// insert position: the last equal entry, else the first greatest smaller one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rqpi_scan
    import rqpi_pkg::*;
(
    input  wire logic      aclk,
    input  wire scan_ctl_t ctl,
    input  wire data_t     entry,
    input  wire idx_t      entry_idx,
    input  wire data_t     value,
    output scan_res_t      res
);

    logic  found_reg, found_next;
    idx_t  pos_reg, pos_next;
    data_t best_reg, best_next;
    logic  is_less, is_equal, is_better;

    assign is_less   = $signed(entry) < $signed(value);
    assign is_equal  = entry == value;
    assign is_better = $signed(entry) > $signed(best_reg);

    always_comb begin
        found_next = found_reg;
        pos_next   = pos_reg;
        best_next  = best_reg;
        if (ctl.clr) begin
            found_next = 1'b0;
        end else if (ctl.en) begin
            if ((is_less && (!found_reg || is_better)) || is_equal) begin
                found_next = 1'b1;
                pos_next   = entry_idx;
                best_next  = entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        found_reg <= found_next;
        pos_reg   <= pos_next;
        best_reg  <= best_next;
    end

    assign res.found = found_reg;
    assign res.pos   = pos_reg;

endmodule

`default_nettype wire

// ===== hdl/ring_queue_with_priority_insert.sv =====
// ----------------------------------------------------------------------------
// Ring queue with priority insert
// Circular queue of signed words with tail append, ordered insert and front
// removal; each transfer in returns one status transfer out.
// ----------------------------------------------------------------------------
// Channel   Ports    Contents (lowest bit up)
// input     s_axis   tuser: operation[1:0]; tdata: value[31:0]
// output    m_axis   tdata: front_value[31:0], is_empty, is_full, status[1:0], pad
//
// Plain insert, remove and refused operations go through the S_FRONT and
// S_LOAD states to the result. A priority insert over n stored entries
// scans them with one RAM read per cycle, then appends or, when it goes in
// at position p, moves one entry per cycle to open slot p. The single
// RAM read port sets that pace. Reset empties the queue; the RAM contents
// are not cleared. A stalled result holds the next one back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ring_queue_with_priority_insert
    import rqpi_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // value[31:0]
    input  wire logic [OP_W-1:0]  s_axis_tuser,   // operation[1:0]
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata    // front_value, is_empty, is_full, status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FRONT,
        S_LOAD
    } state_t;

    state_t           state_reg, state_next;
    idx_t             head_reg, head_next;
    idx_t             tail_reg, tail_next;
    data_t            val_reg, val_next;
    stat_t            status_reg, status_next;
    idx_t             kr_reg, kr_next;
    logic             cv_reg, cv_next;
    idx_t             ck_reg, ck_next;
    idx_t             sk_reg, sk_next;
    logic             iss_reg, iss_next;
    logic             wv_reg, wv_next;
    idx_t             wk_reg, wk_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic      ram_we;
    idx_t      ram_waddr, ram_raddr;
    data_t     ram_wdata, ram_rdata;
    scan_ctl_t scan_ctl;
    scan_res_t scan_res;

    logic  in_fire;
    logic  q_empty, q_full;
    idx_t  fill, first;
    data_t in_value;

    logic  out_is_empty, out_is_full;
    data_t out_front;
    stat_t out_status;

    assign in_value = s_axis_tdata[DATA_W-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign q_empty  = head_reg == tail_reg;
    assign q_full   = slot_inc(tail_reg) == head_reg;
    assign fill     = slot_fill(head_reg, tail_reg);
    assign first    = slot_inc(head_reg);

    rqpi_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rqpi_scan u_scan (
        .aclk      (aclk),
        .ctl       (scan_ctl),
        .entry     (ram_rdata),
        .entry_idx (ck_reg),
        .value     (val_reg),
        .res       (scan_res)
    );

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        kr_next       = kr_reg;
        cv_next       = cv_reg;
        ck_next       = ck_reg;
        sk_next       = sk_reg;
        iss_next      = iss_reg;
        wv_next       = wv_reg;
        wk_next       = wk_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_inc(tail_reg);
        ram_wdata     = val_reg;
        ram_raddr     = first;
        scan_ctl      = '0;
        s_axis_tready = state_reg == S_IDLE;

        if (m_tvalid_reg && m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    val_next    = in_value;
                    status_next = ST_DONE;
                    state_next  = S_FRONT;
                    case (s_axis_tuser)
                        OP_PUSH: begin
                            if (q_full) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = in_value;
                                tail_next = slot_inc(tail_reg);
                            end
                        end
                        OP_PRIO: begin
                            if (q_full) begin
                                status_next = ST_FULL;
                            end else begin
                                scan_ctl.clr = 1'b1;
                                kr_next      = '0;
                                cv_next      = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        OP_POP: begin
                            if (q_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                head_next = first;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_raddr   = slot_add(first, kr_reg);
                scan_ctl.en = cv_reg;
                if (kr_reg != fill) begin
                    kr_next = kr_reg + idx_t'(1);
                    cv_next = 1'b1;
                    ck_next = kr_reg;
                end else begin
                    cv_next = 1'b0;
                end
                if (kr_reg == fill && !cv_reg) begin
                    if (!scan_res.found) begin
                        ram_we     = 1'b1;
                        tail_next  = slot_inc(tail_reg);
                        state_next = S_FRONT;
                    end else begin
                        sk_next    = fill - idx_t'(1);
                        iss_next   = 1'b1;
                        wv_next    = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                ram_raddr = slot_add(first, sk_reg);
                if (iss_reg) begin
                    wk_next = sk_reg + idx_t'(1);
                    wv_next = 1'b1;
                    if (sk_reg == scan_res.pos) begin
                        iss_next = 1'b0;
                    end else begin
                        sk_next = sk_reg - idx_t'(1);
                    end
                end else begin
                    wv_next = 1'b0;
                end
                if (wv_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_add(first, wk_reg);
                    ram_wdata = ram_rdata;
                end else if (!iss_reg) begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_add(first, scan_res.pos);
                    tail_next  = slot_inc(tail_reg);
                    state_next = S_FRONT;
                end
            end
            S_FRONT: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[DATA_W-1:0] = q_empty ? '1 : ram_rdata;
                    m_tdata_next[DATA_W]     = q_empty;
                    m_tdata_next[DATA_W+1]   = q_full;
                    m_tdata_next[DATA_W+2+:STAT_W] = status_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= idx_t'(SLOTS - 1);
            tail_reg     <= idx_t'(SLOTS - 1);
            cv_reg       <= 1'b0;
            iss_reg      <= 1'b0;
            wv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cv_reg       <= cv_next;
            iss_reg      <= iss_next;
            wv_reg       <= wv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        val_reg     <= val_next;
        status_reg  <= status_next;
        kr_reg      <= kr_next;
        ck_reg      <= ck_next;
        sk_reg      <= sk_next;
        wk_reg      <= wk_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    assign out_front    = m_tdata_reg[DATA_W-1:0];
    assign out_is_empty = m_tdata_reg[DATA_W];
    assign out_is_full  = m_tdata_reg[DATA_W+1];
    assign out_status   = stat_t'(m_tdata_reg[DATA_W+2+:STAT_W]);

    `RQ_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_fire, !s_axis_tready)
    `RQ_ASSERT(a_empty_front, aclk, aresetn, !(m_tvalid_reg && out_is_empty) || (out_front == '1))
    `RQ_ASSERT(a_full_refusal, aclk, aresetn, !(m_tvalid_reg && out_status == ST_FULL) || out_is_full)
    `RQ_ASSERT(a_not_both, aclk, aresetn, !(q_empty && q_full))

endmodule

`default_nettype wire

// ===== tb/sv/tb_ring_queue_with_priority_insert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring queue with priority insert testbench
// Self-checking bench: directed rows followed by random operation mixes. A
// behavioral copy of the ring predicts the front, flags and status of every
// accepted transfer, and each result transfer is compared in order. Both
// channels idle in random bursts, the result side also holds off long enough
// to back the block up, and the sender once waits until the queue of
// predictions has drained.
// ----------------------------------------------------------------------------

module tb_ring_queue_with_priority_insert;
    import rqpi_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 450;
    localparam int BLOCK_ITEMS  = 30;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        data_t front;
        logic  empty;
        logic  full;
        stat_t status;
    } queue_view_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        data_t           value;
        logic            pinned;
        queue_view_t     view;
    } stim_row_t;

    localparam queue_view_t NO_VIEW = '0;

    // Only the first rows carry a typed result; the rest rely on the predictor.
    localparam stim_row_t DIRECTED [DIR_ROWS] = '{
        '{OP_POP,    32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, ST_EMPTY}},
        '{OP_UNUSED, 32'h1234_5678, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE}},
        '{OP_PRIO,   32'h0000_0005, 1'b1, '{32'h0000_0005, 1'b0, 1'b0, ST_DONE}},
        '{OP_PUSH,   32'h7FFF_FFFF, 1'b1, '{32'h0000_0005, 1'b0, 1'b0, ST_DONE}},
        '{OP_PUSH,   32'h8000_0000, 1'b1, '{32'h0000_0005, 1'b0, 1'b0, ST_DONE}},
        '{OP_PRIO,   32'h0000_0005, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h0000_0064, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h8000_0000, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'hFFFF_FFFD, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h7FFF_FFFF, 1'b0, NO_VIEW},
        '{OP_PUSH,   32'hFFFF_FFFF, 1'b0, NO_VIEW},
        '{OP_PUSH,   32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'hFFFF_FFFF, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_PUSH,   32'hAAAA_AAAA, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h5555_5555, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h0000_0005, 1'b0, NO_VIEW},
        '{OP_PUSH,   32'h0000_0001, 1'b0, NO_VIEW},
        '{OP_PRIO,   32'h0000_0001, 1'b0, NO_VIEW},
        '{OP_UNUSED, 32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_POP,    32'hFFFF_FFFF, 1'b0, NO_VIEW},
        '{OP_POP,    32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_POP,    32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_POP,    32'h0000_0000, 1'b0, NO_VIEW},
        '{OP_POP,    32'h0000_0000, 1'b0, NO_VIEW}
    };

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic              pin_valid     = 1'b0;
    queue_view_t       pin_view      = '0;

    data_t             ring_mem [SLOTS];
    int                ring_head     = SLOTS - 1;
    int                ring_tail     = SLOTS - 1;
    queue_view_t       pending_views [$];

    int                bad_transfers = 0;
    int                cycle_count   = 0;
    int                idle_pct      = 0;
    logic              hold_request  = 1'b0;

    ring_queue_with_priority_insert DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int ring_slot(input int k);
        return (ring_head + 1 + k) % SLOTS;
    endfunction

    // Applies one operation to the ring copy and returns the view of the queue after it.
    function automatic queue_view_t next_queue_view(input logic [OP_W-1:0] op,
                                                    input data_t value);
        queue_view_t view;
        int          count;
        int          entry;
        int          best;
        int          pos;
        logic        found;
        view.status = ST_DONE;
        count = (ring_tail + SLOTS - ring_head) % SLOTS;
        if (op == OP_PUSH || op == OP_PRIO) begin
            if ((ring_tail + 1) % SLOTS == ring_head) begin
                view.status = ST_FULL;
            end else begin
                found = 1'b0;
                pos   = 0;
                best  = 0;
                if (op == OP_PRIO) begin
                    for (int k = 0; k < count; k++) begin
                        entry = ring_mem[ring_slot(k)];
                        if (entry < int'(value)) begin
                            if (!found || entry > best) begin
                                found = 1'b1;
                                pos   = k;
                                best  = entry;
                            end
                        end else if (entry == int'(value)) begin
                            found = 1'b1;
                            pos   = k;
                            best  = entry;
                        end
                    end
                end
                if (found) begin
                    for (int k = count; k > pos; k--) begin
                        ring_mem[ring_slot(k)] = ring_mem[ring_slot(k - 1)];
                    end
                    ring_mem[ring_slot(pos)] = value;
                end else begin
                    ring_mem[(ring_tail + 1) % SLOTS] = value;
                end
                ring_tail = (ring_tail + 1) % SLOTS;
            end
        end else if (op == OP_POP) begin
            if (count == 0) begin
                view.status = ST_EMPTY;
            end else begin
                ring_head = (ring_head + 1) % SLOTS;
            end
        end
        view.empty = (ring_head == ring_tail);
        view.full  = ((ring_tail + 1) % SLOTS == ring_head);
        view.front = view.empty ? 32'hFFFF_FFFF : ring_mem[(ring_head + 1) % SLOTS];
        return view;
    endfunction

    always @(posedge aclk) begin : scoreboard
        queue_view_t seen;
        queue_view_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = next_queue_view(s_axis_tuser, s_axis_tdata[DATA_W-1:0]);
                if (pin_valid) begin
                    want = pin_view;
                end
                pending_views.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.front  = m_axis_tdata[DATA_W-1:0];
                seen.empty  = m_axis_tdata[DATA_W];
                seen.full   = m_axis_tdata[DATA_W+1];
                seen.status = stat_t'(m_axis_tdata[DATA_W+2 +: STAT_W]);
                if (pending_views.size() == 0) begin
                    if (bad_transfers < REPORT_MAX) begin
                        $display("unexpected result transfer: front=%h empty=%b full=%b status=%0d",
                                 seen.front, seen.empty, seen.full, seen.status);
                    end
                    bad_transfers++;
                end else begin
                    want = pending_views.pop_front();
                    if (seen.front !== want.front || seen.empty !== want.empty ||
                        seen.full !== want.full || seen.status !== want.status) begin
                        if (bad_transfers < REPORT_MAX) begin
                            $display("mismatch: front %h/%h empty %b/%b full %b/%b status %0d/%0d",
                                     want.front, seen.front, want.empty, seen.empty,
                                     want.full, seen.full, want.status, seen.status);
                        end
                        bad_transfers++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : result_sink
        int hold_cnt;
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge aclk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(1, 12);
                repeat (stall) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    // Raises valid with the item and returns at the edge of its transfer.
    task automatic offer_item(input logic [OP_W-1:0] op, input data_t value,
                              input logic pinned, input queue_view_t view);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        pin_valid     <= pinned;
        pin_view      <= view;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic data_t random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return data_t'(int'($urandom_range(0, 16)) - 8);
            5: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int               insert_pct;
        int               roll;
        logic [OP_W-1:0]  op;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_pct = 15;
        for (int i = 0; i < DIR_ROWS; i++) begin
            sender_gap();
            offer_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].pinned, DIRECTED[i].view);
        end

        insert_pct = 55;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % BLOCK_ITEMS == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 25;
                    default: insert_pct = 55;
                endcase
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
                idle_pct = 0;
            end
            if (i == RANDOM_ITEMS / 3) begin
                hold_request = 1'b1;
            end
            if (i == (2 * RANDOM_ITEMS) / 3) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_views.size() != 0) @(posedge aclk);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_UNUSED;
            end else if (roll < insert_pct) begin
                op = ($urandom_range(0, 9) < 6) ? OP_PRIO : OP_PUSH;
            end else begin
                op = OP_POP;
            end
            sender_gap();
            offer_item(op, random_value(), 1'b0, NO_VIEW);
        end

        s_axis_tvalid <= 1'b0;
        pin_valid     <= 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_transfers == 0 && pending_views.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
